// File: design/aesctr_pkg.sv
package aesctr_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int BLOCK_BITS  = 8 * BLOCK_BYTES;
  localparam int ROUNDS      = 10;

  typedef logic [BLOCK_BITS-1:0] block_t;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_HIGH  = 2'd0;
  localparam logic [1:0] REG_KEY_LOW   = 2'd1;
  localparam logic [1:0] REG_CTR_HIGH  = 2'd2;
  localparam logic [1:0] REG_CTR_LOW   = 2'd3;

  // Control from the byte side to the keystream queue
  typedef struct packed {
    logic pop;
    logic flush;
  } ks_ctrl_t;

  // Status from the keystream queue to the byte side
  typedef struct packed {
    logic   valid;
    block_t block;
  } ks_stat_t;

  // Control from the queue to the cipher engine
  typedef struct packed {
    logic start;
    logic abort;
  } core_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Bump bytes 15..1 big-endian; byte 0 holds, carry out of byte 1 drops
  function automatic block_t ctr_inc(input block_t c);
    block_t r;
    r = c;
    r[63:0] = c[63:0] + 64'd1;
    if (&c[63:0]) begin
      r[119:64] = c[119:64] + 56'd1;
    end
    return r;
  endfunction

endpackage

// File: design/aesctr_if.sv
interface aesctr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       last_in;

  modport source(output valid, output cipher_byte, output last_in, input ready);
  modport sink(input valid, input cipher_byte, input last_in, output ready);
endinterface

interface aesctr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       last_out;

  modport source(output valid, output plain_byte, output last_out, input ready);
  modport sink(input valid, input plain_byte, input last_out, output ready);
endinterface

// File: design/aes128_ctr_stream_decrypt_unit.sv
// Channel   Modport  Payload                    Moves
// cipher    sink     cipher_byte[7:0], last_in  one ciphertext byte per request
// plain     source   plain_byte[7:0], last_out  one plaintext byte per request
// wr_*      input    wr_index[1:0], wr_data     one register write per cycle
//
// Sustained rate is one byte per cycle while plain is ready: the iterative cipher
// engine makes one 16-byte keystream block at a time and a two-entry block queue keeps it ahead.
// After reset, after a last byte and after a register write between messages the
// engine restarts from the starting counter; input stalls until a block is queued.
// A write during a message takes effect at the next message start.
// Reset is synchronous; each byte is presented in the cycle after it is accepted,
// through the output register; a stalled plain side holds that byte and stalls the input.
module aes128_ctr_stream_decrypt_unit import aesctr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  aesctr_in_if.sink   cipher,
  aesctr_out_if.source plain,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [63:0] wr_data
);

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [63:0] ctr_high;
  logic [63:0] ctr_low;
  logic [3:0]  pos;
  logic        acc;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [7:0]  ks_byte;
  ks_ctrl_t    ks_ctrl;
  ks_stat_t    ks_stat;
  logic        in_msg;
  block_t      cfg_key_next;
  block_t      cfg_ctr_next;
  block_t      run_key;

  // Register file; new values reach the engine at the next queue flush
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= 64'd0;
      key_low  <= 64'd0;
      ctr_high <= 64'd0;
      ctr_low  <= 64'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_KEY_HIGH: key_high <= wr_data;
        REG_KEY_LOW:  key_low  <= wr_data;
        REG_CTR_HIGH: ctr_high <= wr_data;
        REG_CTR_LOW:  ctr_low  <= wr_data;
        default:      ;
      endcase
    end
  end

  // Register contents as they stand after this edge
  always_comb begin
    cfg_key_next = {key_high, key_low};
    cfg_ctr_next = {ctr_high, ctr_low};
    if (rst) begin
      cfg_key_next = '0;
      cfg_ctr_next = '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_KEY_HIGH: cfg_key_next[127:64] = wr_data;
        REG_KEY_LOW:  cfg_key_next[63:0]   = wr_data;
        REG_CTR_HIGH: cfg_ctr_next[127:64] = wr_data;
        REG_CTR_LOW:  cfg_ctr_next[63:0]   = wr_data;
      endcase
    end
  end

  // Take a byte when a keystream block is queued and the output can move
  assign cipher.ready = ks_stat.valid && (!out_valid || plain.ready);
  assign acc          = cipher.valid && cipher.ready;

  // Drop the queue at end of message or on a register write between messages;
  // pop after byte 15
  assign ks_ctrl.flush = (wr_en && !in_msg && !acc) || (acc && cipher.last_in);
  assign ks_ctrl.pop   = acc && !cipher.last_in && (pos == 4'd15);

  // Key of the current message, latched at every flush
  always_ff @(posedge clk) begin
    if (rst) begin
      run_key <= '0;
      in_msg  <= 1'b0;
    end else begin
      if (ks_ctrl.flush) begin
        run_key <= cfg_key_next;
      end
      if (acc) begin
        in_msg <= !cipher.last_in;
      end
    end
  end

  aesctr_ksq u_ksq (
    .clk      (clk),
    .rst      (rst),
    .key      (run_key),
    .ctr_init (cfg_ctr_next),
    .ctrl     (ks_ctrl),
    .stat     (ks_stat)
  );

  // Byte 0 sits in the top bits of the block
  assign ks_byte = ks_stat.block[{~pos, 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        pos       <= cipher.last_in ? 4'd0 : pos + 4'd1;
        out_valid <= 1'b1;
      end else if (plain.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_byte <= cipher.cipher_byte ^ ks_byte;
      out_last <= cipher.last_in;
    end
  end

  assign plain.valid      = out_valid;
  assign plain.plain_byte = out_byte;
  assign plain.last_out   = out_last;

  a_last_rewinds: assert property (@(posedge clk) disable iff (rst)
    acc && cipher.last_in |=> pos == 4'd0)
    else $error("position not rewound after last byte");

  a_block_wrap: assert property (@(posedge clk) disable iff (rst)
    acc && !cipher.last_in && pos == 4'd15 |=> pos == 4'd0)
    else $error("position did not wrap at block end");

  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    acc |=> plain.valid)
    else $error("accepted byte not presented");

endmodule

// File: design/aesctr_core.sv
module aesctr_core import aesctr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  core_ctrl_t ctrl,
  input  block_t     key,
  input  block_t     ctr,
  output logic       busy,
  output logic       done,
  output block_t     block
);

  block_t     st;
  block_t     rk;
  logic [7:0] rcon;
  logic [3:0] rnd;

  // One cipher round without the round key
  function automatic block_t enc_round(input block_t s, input logic final_r);
    logic [7:0] a [16];
    logic [7:0] n [16];
    logic [7:0] o [16];
    logic [7:0] all;
    block_t     r;
    for (int k = 0; k < 16; k++) begin
      a[k] = s[8*(15-k) +: 8];
    end
    for (int rr = 0; rr < 4; rr++) begin
      for (int c = 0; c < 4; c++) begin
        n[rr + 4*c] = SBOX[a[rr + 4*((c + rr) & 3)]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all = n[4*c] ^ n[4*c+1] ^ n[4*c+2] ^ n[4*c+3];
      o[4*c]   = n[4*c]   ^ all ^ xtime(n[4*c]   ^ n[4*c+1]);
      o[4*c+1] = n[4*c+1] ^ all ^ xtime(n[4*c+1] ^ n[4*c+2]);
      o[4*c+2] = n[4*c+2] ^ all ^ xtime(n[4*c+2] ^ n[4*c+3]);
      o[4*c+3] = n[4*c+3] ^ all ^ xtime(n[4*c+3] ^ n[4*c]);
    end
    for (int k = 0; k < 16; k++) begin
      r[8*(15-k) +: 8] = final_r ? n[k] : o[k];
    end
    return r;
  endfunction

  function automatic block_t key_step(input block_t k, input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  block_t rk_next;
  logic   final_rnd;

  assign final_rnd = (rnd == 4'(ROUNDS));
  assign rk_next   = key_step(rk, rcon);
  assign block     = st;

  always_ff @(posedge clk) begin
    if (rst || ctrl.abort) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      st   <= ctr ^ key;
      rk   <= key;
      rcon <= 8'h01;
      rnd  <= 4'd1;
    end else begin
      done <= busy && final_rnd;
      if (busy) begin
        st   <= enc_round(st, final_rnd) ^ rk_next;
        rk   <= rk_next;
        rcon <= xtime(rcon);
        rnd  <= rnd + 4'd1;
        if (final_rnd) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: design/aesctr_ksq.sv
module aesctr_ksq import aesctr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  block_t   key,
  input  block_t   ctr_init,
  input  ks_ctrl_t ctrl,
  output ks_stat_t stat
);

  block_t     ctr;
  block_t     slots [2];
  logic       head;
  logic [1:0] count;
  core_ctrl_t core_ctrl;
  logic       core_busy;
  logic       core_done;
  block_t     core_block;
  logic       wr_slot;

  // Start the next block only with a free slot and no result in flight
  assign core_ctrl.abort = ctrl.flush;
  assign core_ctrl.start = !ctrl.flush && !core_busy && !core_done && (count < 2'd2);
  assign wr_slot         = head ^ count[0];

  aesctr_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (core_ctrl),
    .key   (key),
    .ctr   (ctr),
    .busy  (core_busy),
    .done  (core_done),
    .block (core_block)
  );

  always_ff @(posedge clk) begin
    if (rst || ctrl.flush) begin
      ctr   <= ctr_init;
      head  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (core_ctrl.start) begin
        ctr <= ctr_inc(ctr);
      end
      if (core_done) begin
        slots[wr_slot] <= core_block;
      end
      head  <= head ^ ctrl.pop;
      count <= count + {1'b0, core_done} - {1'b0, ctrl.pop};
    end
  end

  assign stat.valid = (count != 2'd0);
  assign stat.block = slots[head];

endmodule

// File: tb/aesctr_stream_checker.sv
`timescale 1ns / 1ps

module aesctr_stream_checker import aesctr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [63:0] wr_data,
  output int          fail_count,
  output int          bytes_pending
);

  typedef struct packed {
    logic [7:0] plain;
    logic       last;
  } plain_rec_t;

  logic [127:0] key_reg, ctr_init_reg;
  logic [127:0] msg_key, ctr_cur, ks_block;
  logic [3:0]   pos;
  logic         at_start;
  plain_rec_t   plain_q[$];

  function automatic logic [7:0] sb(input logic [7:0] x);
    return SBOX[x];
  endfunction

  function automatic logic [7:0] gmul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Standard AES-128 forward cipher; byte 0 is bits [127:120]
  function automatic logic [127:0] aes_encrypt(input logic [127:0] k, input logic [127:0] pt);
    logic [7:0] w[176];
    logic [7:0] t[4];
    logic [7:0] s[16];
    logic [7:0] n[16];
    logic [7:0] rc;
    logic [7:0] tmp, a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) w[i] = k[127-8*i -: 8];
    rc = 8'h01;
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) t[j] = w[i-4+j];
      if (i % 16 == 0) begin
        tmp = t[0];
        t[0] = sb(t[1]) ^ rc;
        t[1] = sb(t[2]);
        t[2] = sb(t[3]);
        t[3] = sb(tmp);
        rc = gmul2(rc);
      end
      for (int j = 0; j < 4; j++) w[i+j] = w[i-16+j] ^ t[j];
    end
    for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ w[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int rr = 0; rr < 4; rr++)
        for (int c = 0; c < 4; c++) n[rr+4*c] = sb(s[rr+4*((c+rr)%4)]);
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = n[4*c]; a1 = n[4*c+1]; a2 = n[4*c+2]; a3 = n[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
          s[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
          s[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
          s[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
        end
      end else begin
        s = n;
      end
      for (int i = 0; i < 16; i++) s[i] ^= w[16*rnd+i];
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
    return r;
  endfunction

  assign bytes_pending = plain_q.size();

  always @(posedge clk) begin
    logic [127:0] ctr_now, ks_now;
    logic [3:0]   p;
    plain_rec_t   exp_rec;
    int           errs;
    errs = 0;
    if (rst) begin
      key_reg <= '0;
      ctr_init_reg <= '0;
      pos <= '0;
      at_start <= 1'b1;
      fail_count <= 0;
      plain_q.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_KEY_HIGH: key_reg[127:64] <= wr_data;
          REG_KEY_LOW:  key_reg[63:0] <= wr_data;
          REG_CTR_HIGH: ctr_init_reg[127:64] <= wr_data;
          REG_CTR_LOW:  ctr_init_reg[63:0] <= wr_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        ctr_now = ctr_cur;
        p = pos;
        ks_now = ks_block;
        if (at_start) begin
          msg_key = key_reg;
          ctr_now = ctr_init_reg;
          p = '0;
        end
        if (p == 0) ks_now = aes_encrypt(msg_key, ctr_now);
        exp_rec.plain = in_byte ^ ks_now[127-8*p -: 8];
        exp_rec.last = in_last;
        plain_q.push_back(exp_rec);
        ks_block <= ks_now;
        if (in_last) begin
          at_start <= 1'b1;
          pos <= '0;
        end else begin
          at_start <= 1'b0;
          // advance the counter after the final byte of a block
          ctr_cur <= (p == 15) ? ctr_inc(ctr_now) : ctr_now;
          pos <= p + 4'd1;
        end
      end
      if (out_valid && out_ready) begin
        if (plain_q.size() == 0) begin
          $error("plain byte with nothing expected: %h", out_byte);
          errs++;
        end else begin
          exp_rec = plain_q.pop_front();
          if (out_byte !== exp_rec.plain) begin
            $error("plain_byte: expected %h, got %h", exp_rec.plain, out_byte);
            errs++;
          end
          if (out_last !== exp_rec.last) begin
            $error("last_out: expected %b, got %b", exp_rec.last, out_last);
            errs++;
          end
        end
      end
      if (errs != 0) begin
        fail_count <= fail_count + errs;
      end
    end
  end

endmodule

// File: tb/aes128_ctr_stream_decrypt_unit_tb.sv
`timescale 1ns / 1ps

module aes128_ctr_stream_decrypt_unit_tb;
  import aesctr_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = REG_KEY_HIGH;
  logic [63:0] wr_data = '0;
  int          fail_count;
  int          bytes_pending;
  bit          hold_plain = 1'b0;
  bit          stim_done = 1'b0;

  aesctr_in_if  cipher_ch();
  aesctr_out_if plain_ch();

  aes128_ctr_stream_decrypt_unit i_dut (
    .clk(clk), .rst(rst), .cipher(cipher_ch.sink), .plain(plain_ch.source),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  aesctr_stream_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(cipher_ch.valid), .in_ready(cipher_ch.ready),
    .in_byte(cipher_ch.cipher_byte), .in_last(cipher_ch.last_in),
    .out_valid(plain_ch.valid), .out_ready(plain_ch.ready),
    .out_byte(plain_ch.plain_byte), .out_last(plain_ch.last_out),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .fail_count(fail_count), .bytes_pending(bytes_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cipher_ch.valid = 1'b0;
    cipher_ch.cipher_byte = '0;
    cipher_ch.last_in = 1'b0;
    plain_ch.ready = 1'b0;
  end

  // Send one request; hold valid until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic lst, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    // drop valid only when the request does not follow right away
    if (gap != 0) begin
      cipher_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cipher_ch.valid <= 1'b1;
    cipher_ch.cipher_byte <= b;
    cipher_ch.last_in <= lst;
    do @(posedge clk); while (!cipher_ch.ready);
  endtask

  task automatic drain_results();
    while (bytes_pending != 0) @(posedge clk);
    // the engine may still be filling its keystream queue; let it settle
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic load_settings(input logic [63:0] kh, input logic [63:0] kl,
                               input logic [63:0] ch, input logic [63:0] cl);
    cipher_ch.valid <= 1'b0;
    drain_results();
    write_reg(REG_KEY_HIGH, kh);
    write_reg(REG_KEY_LOW, kl);
    write_reg(REG_CTR_HIGH, ch);
    write_reg(REG_CTR_LOW, cl);
  endtask

  // Send a message of random bytes; a streak with no gaps at random.
  task automatic send_message(input int len);
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1, burst);
    end
  endtask

  // Receiver: random stall per request, with long hold-offs on request.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (hold_plain) begin
        plain_ch.ready <= 1'b0;
        @(posedge clk);
      end else begin
        stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 9);
        if (stall != 0) begin
          plain_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        plain_ch.ready <= 1'b1;
        do @(posedge clk); while (!plain_ch.valid);
      end
    end
  end

  initial begin
    int sent;
    int len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of key and counter, byte extremes, wrap of bytes 1..15
    load_settings('1, '1, 64'h00ff_ffff_ffff_ffff, '1);
    send_byte(8'h00, 1'b0, 1'b0);
    for (int i = 0; i < 16; i++) send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h5a, 1'b1, 1'b0);
    load_settings('0, '0, '0, '0);
    send_byte(8'hff, 1'b1, 1'b0);
    // known vector key 2b7e1516..., partial block then last
    load_settings(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c,
                  64'hf0f1_f2f3_f4f5_f6f7, 64'hf8f9_fafb_fcfd_feff);
    for (int i = 0; i < 5; i++) send_byte(8'($urandom_range(0, 255)), i == 4, 1'b0);

    // Long receiver hold-off while the sender keeps feeding
    fork
      begin
        hold_plain = 1'b1;
        repeat (60) @(posedge clk);
        hold_plain = 1'b0;
      end
      send_message(40);
    join
    // Sender pause until everything has come back
    cipher_ch.valid <= 1'b0;
    while (bytes_pending != 0) @(posedge clk);

    sent = 0;
    while (sent < 390) begin
      if ($urandom_range(0, 5) == 0) begin
        load_settings({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom},
                      ($urandom_range(0, 1) ? 64'hffff_ffff_ffff_fff0 : {$urandom, $urandom}));
      end
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 20);
      send_message(len);
      sent += len;
    end

    cipher_ch.valid <= 1'b0;
    while (bytes_pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    stim_done = 1'b1;
    if (fail_count == 0) begin
      $display("aes128_ctr_stream_decrypt_unit_tb: clean");
    end else begin
      $display("aes128_ctr_stream_decrypt_unit_tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("aes128_ctr_stream_decrypt_unit_tb: errors");
    $finish;
  end

endmodule

// File: files.f
design/aesctr_pkg.sv
design/aesctr_if.sv
design/aesctr_core.sv
design/aesctr_ksq.sv
design/aes128_ctr_stream_decrypt_unit.sv
tb/aesctr_stream_checker.sv
tb/aes128_ctr_stream_decrypt_unit_tb.sv
